[design/bwnc_pkg.sv]
// Shared types, constants and helper functions for the binary window neighbor counter.
`default_nettype none

package bwnc_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF    = 1024;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned WIN_W       = 9;
  localparam int unsigned NUM_RES     = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS    = 2'd1;

  localparam int unsigned RES_INNER  = 0;
  localparam int unsigned RES_RIGHT  = 1;
  localparam int unsigned RES_BOTTOM = 2;
  localparam int unsigned RES_CORNER = 3;

  localparam logic [WIN_W-1:0] WIN_ALL        = 9'h1FF;
  localparam logic [WIN_W-1:0] WIN_RIGHT_TWO  = 9'h1F8;
  localparam logic [WIN_W-1:0] WIN_LOWER_TWO  = 9'h1B6;
  localparam logic [WIN_W-1:0] WIN_LOWER_FOUR = 9'h1B0;

  typedef struct packed {
    logic [NUM_RES-1:0] mask;
    logic [WIN_W-1:0]   window;
  } run_t;

  function automatic logic [COUNT_W-1:0] popcount9(input logic [WIN_W-1:0] v);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < WIN_W; k++) begin
      n = n + COUNT_W'(v[k]);
    end
    return n;
  endfunction

  function automatic int unsigned clamp_reg(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned maxv);
    int unsigned x;
    x = 32'(v);
    if (x == 0) begin
      return 1;
    end
    if (x > maxv) begin
      return maxv;
    end
    return x;
  endfunction

endpackage

`default_nettype wire

[design/bwnc_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module bwnc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = bwnc_pkg::MAX_COLUMNS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/bwnc_window.sv]
// Line store read-modify-write stage and 3x3 window shift register.
`default_nettype none

module bwnc_window #(
  parameter int unsigned MAX_COLUMNS = bwnc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = bwnc_pkg::MAX_ROWS_DEF,
  localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc_i,
  input  wire logic          acc_marked_i,
  input  wire logic [RW-1:0] acc_row_i,
  input  wire logic [CW-1:0] acc_col_i,
  input  wire logic          acc_row_end_i,
  input  wire logic          acc_last_row_i,
  input  wire logic          take_i,
  output logic               busy_o,
  output logic               load_o,
  output bwnc_pkg::run_t     run_o,
  output logic [RW-1:0]      run_row_o,
  output logic [CW-1:0]      run_col_o
);

  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_marked_r;
  logic [RW-1:0]                 s1_row_r;
  logic [CW-1:0]                 s1_col_r;
  logic                          s1_row_end_r;
  logic                          s1_last_row_r;
  logic [bwnc_pkg::WIN_W-1:0]    win_r, win_nxt;
  logic                          fwd_r;
  logic [1:0]                    fwd_data_r;
  logic [1:0]                    ram_rdata;
  logic [1:0]                    rd;
  logic [1:0]                    wdata;
  logic                          adv;
  logic                          bit_a, bit_b;
  logic [2:0]                    newcol;
  logic                          has_up, has_left;

  assign adv    = s1_valid_r && take_i;
  assign busy_o = s1_valid_r && !take_i;
  assign load_o = adv;

  bwnc_ram #(
    .WIDTH (2),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk   (clk),
    .we    (adv),
    .waddr (s1_col_r),
    .wdata (wdata),
    .re    (acc_i),
    .raddr (acc_col_i),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd       = fwd_r ? fwd_data_r : ram_rdata;
    has_up   = (s1_row_r != '0);
    has_left = (s1_col_r != '0);
    bit_a    = (32'(s1_row_r) >= 32'd2) ? rd[1] : 1'b0;
    bit_b    = has_up ? rd[0] : 1'b0;
    newcol   = {s1_marked_r, bit_b, bit_a};
    wdata    = {bit_b, s1_marked_r};
    win_nxt  = (has_left ? (win_r >> 3) : '0) | {newcol, 6'd0};
    run_o.window = win_nxt;
    run_o.mask[bwnc_pkg::RES_INNER]  = has_up && has_left;
    run_o.mask[bwnc_pkg::RES_RIGHT]  = has_up && s1_row_end_r;
    run_o.mask[bwnc_pkg::RES_BOTTOM] = s1_last_row_r && has_left;
    run_o.mask[bwnc_pkg::RES_CORNER] = s1_last_row_r && s1_row_end_r;
    run_row_o = s1_row_r;
    run_col_o = s1_col_r;
    s1_valid_nxt = acc_i ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      win_r      <= '0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (adv) begin
        win_r <= win_nxt;
      end
      if (acc_i) begin
        fwd_r <= adv && (s1_col_r == acc_col_i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_i) begin
      s1_marked_r   <= acc_marked_i;
      s1_row_r      <= acc_row_i;
      s1_col_r      <= acc_col_i;
      s1_row_end_r  <= acc_row_end_i;
      s1_last_row_r <= acc_last_row_i;
      fwd_data_r    <= wdata;
    end
  end

  a_acc_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    acc_i |-> (!s1_valid_r || take_i))
    else $error("Transaction taken while the window stage was still occupied.");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && adv && (s1_col_r == acc_col_i)) |=> fwd_r)
    else $error("Same-column write was not forwarded to the following read.");

endmodule

`default_nettype wire

[design/bwnc_emit.sv]
// Result sequencer that delivers up to four counts per cell through an output register.
`default_nettype none

module bwnc_emit #(
  parameter int unsigned MAX_COLUMNS = bwnc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = bwnc_pkg::MAX_ROWS_DEF,
  localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              load_i,
  input  wire bwnc_pkg::run_t                    run_i,
  input  wire logic [RW-1:0]                     run_row_i,
  input  wire logic [CW-1:0]                     run_col_i,
  output logic                                   take_o,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bwnc_pkg::COUNT_W-1:0]           out_window_count,
  output logic [RW-1:0]                          out_row,
  output logic [CW-1:0]                          out_column,
  output logic                                   out_last_of_run,
  output logic                                   out_frame_done
);

  logic [bwnc_pkg::NUM_RES-1:0] mask_r, mask_nxt;
  logic [bwnc_pkg::WIN_W-1:0]   win_r;
  logic [RW-1:0]                row_r;
  logic [CW-1:0]                col_r;
  logic [bwnc_pkg::NUM_RES-1:0] low, rest;
  logic [bwnc_pkg::WIN_W-1:0]   sel_win;
  logic                         out_free, emit_go;
  logic                         out_valid_r, out_valid_nxt;
  logic [bwnc_pkg::COUNT_W-1:0] out_count_r;
  logic [RW-1:0]                out_row_r;
  logic [CW-1:0]                out_col_r;
  logic                         out_last_r, out_done_r;

  always_comb begin
    low      = mask_r & (~mask_r + 1'b1);
    rest     = mask_r & ~low;
    out_free = !out_valid_r || !out_stall;
    emit_go  = (mask_r != '0) && out_free;
    take_o   = (mask_r == '0) || (out_free && (rest == '0));
    if (low[bwnc_pkg::RES_INNER]) begin
      sel_win = win_r & bwnc_pkg::WIN_ALL;
    end else if (low[bwnc_pkg::RES_RIGHT]) begin
      sel_win = win_r & bwnc_pkg::WIN_RIGHT_TWO;
    end else if (low[bwnc_pkg::RES_BOTTOM]) begin
      sel_win = win_r & bwnc_pkg::WIN_LOWER_TWO;
    end else begin
      sel_win = win_r & bwnc_pkg::WIN_LOWER_FOUR;
    end
    mask_nxt      = load_i ? run_i.mask : (emit_go ? rest : mask_r);
    out_valid_nxt = emit_go ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      win_r <= run_i.window;
      row_r <= run_row_i;
      col_r <= run_col_i;
    end
    if (emit_go) begin
      out_count_r <= bwnc_pkg::popcount9(sel_win);
      out_row_r   <= (low[bwnc_pkg::RES_INNER] || low[bwnc_pkg::RES_RIGHT]) ?
                     row_r - 1'b1 : row_r;
      out_col_r   <= (low[bwnc_pkg::RES_INNER] || low[bwnc_pkg::RES_BOTTOM]) ?
                     col_r - 1'b1 : col_r;
      out_last_r  <= (rest == '0);
      out_done_r  <= low[bwnc_pkg::RES_CORNER];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_count = out_count_r;
  assign out_row          = out_row_r;
  assign out_column       = out_col_r;
  assign out_last_of_run  = out_last_r;
  assign out_frame_done   = out_done_r;

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_last_r)
    else $error("Final cell of the grid was not the last result of its cell.");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> take_o)
    else $error("New cell loaded while earlier results were still pending.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r <= bwnc_pkg::COUNT_W'(9)))
    else $error("Window count exceeds nine.");

endmodule

`default_nettype wire

[design/binary_window_neighbor_count.sv]
// Top level of the binary 3x3 window neighbor counter.
//
// Cells of a binary grid enter in raster order on the in_ channel (in_valid, in_stall,
// in_marked). For each cell the block returns, on the out_ channel, the number of marked
// cells in the 3x3 window around it, with the row and column of that cell. A cell at row
// i, column j releases the result of cell (i-1, j-1); the last cell of a row also releases
// (i-1, last column), and cells of the last row release their own row as well, so one
// transaction gives zero to four results, last_of_run marking the final one.
// A transaction's results pass the window stage, the result stage and the output register.
// One cell per cycle is sustained while each cell yields at most one result and out_stall
// is low; a cell with more results holds the input until its last result is emitted.
// Both line stores sit in one 2-bit wide memory, read when a cell is taken and written
// back when that cell moves on to the result stage, which a stalled output side can hold
// back, with a bypass for the single-column case.
// The cfg_ channel writes grid_columns (index 0) and grid_rows (index 1); writing either
// restarts the grid at row 0, column 0. Reset sets both to their maximum and restarts it.
// When out_stall is high the output register holds its result and in_stall rises once
// the pending results fill the pipeline.
`default_nettype none

module binary_window_neighbor_count #(
  parameter int unsigned MAX_COLUMNS = bwnc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = bwnc_pkg::MAX_ROWS_DEF,
  localparam int unsigned CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned NCW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS + 1) : 1,
  localparam int unsigned NRW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS + 1) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_marked,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [bwnc_pkg::COUNT_W-1:0]             out_window_count,
  output logic [RW-1:0]                            out_row,
  output logic [CW-1:0]                            out_column,
  output logic                                     out_last_of_run,
  output logic                                     out_frame_done,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bwnc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [bwnc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [NCW-1:0] cols_r, cols_nxt;
  logic [NRW-1:0] rows_r, rows_nxt;
  logic [CW-1:0]  col_pos_r, col_pos_nxt;
  logic [RW-1:0]  row_pos_r, row_pos_nxt;
  logic           in_accept;
  logic           cfg_we, cfg_restart;
  logic           row_end, last_row;
  logic           win_busy;
  logic           take;
  logic           load;
  bwnc_pkg::run_t run;
  logic [RW-1:0]  run_row;
  logic [CW-1:0]  run_col;

  assign cfg_ready = 1'b1;
  assign in_stall  = win_busy;
  assign in_accept = in_valid && !in_stall;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    row_end  = (32'(col_pos_r) + 32'd1) >= 32'(cols_r);
    last_row = (32'(row_pos_r) + 32'd1) >= 32'(rows_r);
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    cfg_restart = 1'b0;
    if (cfg_we) begin
      if (cfg_index == bwnc_pkg::REG_GRID_COLUMNS) begin
        cols_nxt    = NCW'(bwnc_pkg::clamp_reg(cfg_data, MAX_COLUMNS));
        cfg_restart = 1'b1;
      end else if (cfg_index == bwnc_pkg::REG_GRID_ROWS) begin
        rows_nxt    = NRW'(bwnc_pkg::clamp_reg(cfg_data, MAX_ROWS));
        cfg_restart = 1'b1;
      end
    end
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (cfg_restart) begin
      col_pos_nxt = '0;
      row_pos_nxt = '0;
    end else if (in_accept) begin
      if (row_end) begin
        col_pos_nxt = '0;
        row_pos_nxt = last_row ? '0 : row_pos_r + 1'b1;
      end else begin
        col_pos_nxt = col_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r    <= NCW'(MAX_COLUMNS);
      rows_r    <= NRW'(MAX_ROWS);
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else begin
      cols_r    <= cols_nxt;
      rows_r    <= rows_nxt;
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

  bwnc_window #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc_i          (in_accept),
    .acc_marked_i   (in_marked),
    .acc_row_i      (row_pos_r),
    .acc_col_i      (col_pos_r),
    .acc_row_end_i  (row_end),
    .acc_last_row_i (last_row),
    .take_i         (take),
    .busy_o         (win_busy),
    .load_o         (load),
    .run_o          (run),
    .run_row_o      (run_row),
    .run_col_o      (run_col)
  );

  bwnc_emit #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load_i           (load),
    .run_i            (run),
    .run_row_i        (run_row),
    .run_col_i        (run_col),
    .take_o           (take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_window_count (out_window_count),
    .out_row          (out_row),
    .out_column       (out_column),
    .out_last_of_run  (out_last_of_run),
    .out_frame_done   (out_frame_done)
  );

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && row_end) |=> (col_pos_r == '0))
    else $error("Column position did not wrap at the end of a row.");

endmodule

`default_nettype wire
